/* rtl/vmr_pkg.sv */
`timescale 1ns / 1ps

package vmr_pkg;

    typedef enum logic [3:0] {
        REQ_TEST      = 4'd0,
        REQ_COMPL     = 4'd1,
        REQ_CLZ       = 4'd2,
        REQ_POPCNT    = 4'd3,
        REQ_READVCT   = 4'd4,
        REQ_LOAD      = 4'd5,
        REQ_LOADCOMPL = 4'd6,
        REQ_AND       = 4'd7,
        REQ_OR        = 4'd8,
        REQ_XOR       = 4'd9,
        REQ_READMASK  = 4'd10,
        REQ_RESTORE   = 4'd11,
        REQ_SETVCT    = 4'd12,
        REQ_SETVIX    = 4'd13
    } req_t;

    typedef logic [1:0] cc_t;

    localparam cc_t CC_0 = 2'd0;
    localparam cc_t CC_1 = 2'd1;
    localparam cc_t CC_2 = 2'd2;
    localparam cc_t CC_3 = 2'd3;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned ADDR_W = 32;

endpackage

/* rtl/vector_mask_register_unit_core.sv */
`timescale 1ns / 1ps

// vector mask register unit
// holds the mask register (bit 0 is the msb of the word), the vector count and
// the interruption index, and runs one mask or count operation per item
// input channel: in_valid / in_stall with req_type, operand_bits, address_value
// output channel: out_valid / out_stall with cond_code, result_value
// an item taken in goes through the input register, then the operation logic
// (popcount and leading-zero trees, address clamp) into the result register,
// where it raises out_valid and waits until the receiver does not stall
// throughput is one item per cycle while the output side does not stall; the
// state written by one item is seen by the item right behind it
// when the receiver stalls, the result register holds and in_stall rises only
// while the input register is also full, so up to two items sit inside
// reset clears the mask, the count, the index and both valid flags
// SECTION_SIZE (8 to 64) sets how many top bits of the word form the mask
module vector_mask_register_unit_core #(
    parameter int unsigned SECTION_SIZE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  req_type,
    input  logic [63:0] operand_bits,
    input  logic [31:0] address_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  cond_code,
    output logic [63:0] result_value
);
    import vmr_pkg::*;

    localparam int unsigned CNT_W = $clog2(SECTION_SIZE + 1);
    localparam logic [WORD_W-1:0] SEC_MASK = ~64'd0 << (WORD_W - SECTION_SIZE);
    localparam logic [CNT_W-1:0] SEC_CNT = CNT_W'(SECTION_SIZE);

    localparam logic [63:0] M1  = 64'h5555_5555_5555_5555;
    localparam logic [63:0] M2  = 64'h3333_3333_3333_3333;
    localparam logic [63:0] M4  = 64'h0F0F_0F0F_0F0F_0F0F;
    localparam logic [63:0] M8  = 64'h00FF_00FF_00FF_00FF;
    localparam logic [63:0] M16 = 64'h0000_FFFF_0000_FFFF;
    localparam logic [63:0] M32 = 64'h0000_0000_FFFF_FFFF;

    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [63:0] y;
        logic [6:0]  z;
        y = x;
        z = '0;
        if (y[63:32] == '0)
        begin
            z = z + 7'd32;
            y = y << 32;
        end
        if (y[63:48] == '0)
        begin
            z = z + 7'd16;
            y = y << 16;
        end
        if (y[63:56] == '0)
        begin
            z = z + 7'd8;
            y = y << 8;
        end
        if (y[63:60] == '0)
        begin
            z = z + 7'd4;
            y = y << 4;
        end
        if (y[63:62] == '0)
        begin
            z = z + 7'd2;
            y = y << 2;
        end
        if (y[63] == 1'b0)
        begin
            z = z + 7'd1;
        end
        return z;
    endfunction

    function automatic logic [6:0] popcnt64(input logic [63:0] x);
        logic [63:0] y;
        y = (x & M1) + ((x >> 1) & M1);
        y = (y & M2) + ((y >> 2) & M2);
        y = (y & M4) + ((y >> 4) & M4);
        y = (y & M8) + ((y >> 8) & M8);
        y = (y & M16) + ((y >> 16) & M16);
        y = (y & M32) + ((y >> 32) & M32);
        return y[6:0];
    endfunction

    // input register
    logic              s1_valid_reg;
    req_t              req_reg;
    logic [63:0]       opnd_reg;
    logic signed [31:0] addr_reg;

    // architected state
    logic [63:0]       mask_reg;
    logic [63:0]       mask_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  index_reg;
    logic [CNT_W-1:0]  index_next;

    // result register
    logic              out_valid_reg;
    cc_t               cc_reg;
    cc_t               cc_next;
    logic [63:0]       res_reg;
    logic [63:0]       res_next;

    logic              out_adv;
    logic              s1_fire;
    logic              in_fire;

    logic [CNT_W-1:0]  n_act;
    logic [63:0]       act;
    logic [63:0]       v;
    cc_t               mask_cc;
    logic              addr_neg;
    logic              addr_zero;
    logic              addr_big;
    logic              addr_below;
    logic [CNT_W-1:0]  addr_clamp;

    assign out_adv  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_adv;
    assign in_stall = s1_valid_reg && !out_adv;
    assign in_fire  = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign cond_code    = cc_reg;
    assign result_value = res_reg;

    always_comb
    begin
        n_act = (count_reg > SEC_CNT) ? SEC_CNT : count_reg;
        if (n_act == '0)
        begin
            act = '0;
        end
        else
        begin
            act = ~64'd0 << (7'd64 - 7'(n_act));
        end
        v = mask_reg & act;
        if (act == '0 || v == '0)
        begin
            mask_cc = CC_0;
        end
        else if (v == act)
        begin
            mask_cc = CC_3;
        end
        else
        begin
            mask_cc = CC_1;
        end

        addr_neg   = addr_reg[31];
        addr_zero  = (addr_reg == '0);
        addr_big   = !addr_neg && (addr_reg > $signed(ADDR_W'(SECTION_SIZE)));
        addr_below = !addr_neg && (addr_reg < $signed(ADDR_W'(count_reg)));
        if (addr_neg)
        begin
            addr_clamp = '0;
        end
        else if (addr_big)
        begin
            addr_clamp = SEC_CNT;
        end
        else
        begin
            addr_clamp = addr_reg[CNT_W-1:0];
        end
    end

    always_comb
    begin
        mask_next  = mask_reg;
        count_next = count_reg;
        index_next = index_reg;
        cc_next    = CC_0;
        res_next   = '0;
        case (req_reg)
            REQ_TEST:
            begin
                cc_next = mask_cc;
            end
            REQ_COMPL:
            begin
                mask_next = ~mask_reg & act;
            end
            REQ_CLZ:
            begin
                cc_next = mask_cc;
                if (v == '0)
                begin
                    res_next = 64'(n_act);
                end
                else
                begin
                    res_next = 64'(lzc64(v));
                end
            end
            REQ_POPCNT:
            begin
                cc_next  = mask_cc;
                res_next = 64'(popcnt64(v));
            end
            REQ_READVCT:
            begin
                res_next = 64'(count_reg);
            end
            REQ_LOAD:
            begin
                mask_next = opnd_reg & act;
            end
            REQ_LOADCOMPL:
            begin
                mask_next = ~opnd_reg & act;
            end
            REQ_AND:
            begin
                mask_next = mask_reg & opnd_reg & act;
            end
            REQ_OR:
            begin
                mask_next = (mask_reg | opnd_reg) & act;
            end
            REQ_XOR:
            begin
                mask_next = (mask_reg ^ opnd_reg) & act;
            end
            REQ_READMASK:
            begin
                res_next = mask_reg;
            end
            REQ_RESTORE:
            begin
                mask_next = opnd_reg & SEC_MASK;
            end
            REQ_SETVCT:
            begin
                if (addr_zero)
                begin
                    cc_next = CC_0;
                end
                else if (addr_neg)
                begin
                    cc_next = CC_1;
                end
                else if (addr_big)
                begin
                    cc_next = CC_2;
                end
                else
                begin
                    cc_next = CC_3;
                end
                count_next = addr_clamp;
            end
            REQ_SETVIX:
            begin
                if (addr_zero)
                begin
                    cc_next = CC_0;
                end
                else if (addr_neg)
                begin
                    cc_next = CC_1;
                end
                else if (addr_below)
                begin
                    cc_next = CC_2;
                end
                else
                begin
                    cc_next = CC_3;
                end
                index_next = addr_clamp;
            end
            default:
            begin
                cc_next  = CC_0;
                res_next = '0;
            end
        endcase
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg  <= req_t'(req_type);
            opnd_reg <= operand_bits;
            addr_reg <= $signed(address_value);
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            cc_reg  <= cc_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            count_reg     <= '0;
            index_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                mask_reg      <= mask_next;
                count_reg     <= count_next;
                index_reg     <= index_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/vmr_checker.sv */
`timescale 1ns / 1ps

module vmr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  cond_code,
    input logic [63:0] result_value
);

    // input side backs up only while the result register is full and stalled
    a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled result");

    // a transfer in reaches the output through the input and result registers if the output is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("result missing after transfer");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(cond_code) && $stable(result_value)))
        else $error("stalled result changed");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without transfer");

endmodule

bind vector_mask_register_unit_core vmr_checker u_vmr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cond_code    (cond_code),
    .result_value (result_value)
);
